// File: hdl/ihc_pkg.sv
`default_nettype none
package ihc_pkg;

  localparam int unsigned FrameLen   = 8;
  localparam int unsigned ReportLen  = 11;
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned FrameIdxW  = $clog2(FrameLen);
  localparam int unsigned ReportIdxW = $clog2(ReportLen);
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Input kinds carried on the slave tuser.
  typedef enum logic [1:0] {
    CMD_SENSOR = 2'd0,
    CMD_HOST   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FSTAT_NONE   = 2'd0,
    FSTAT_ACCEPT = 2'd1,
    FSTAT_REJECT = 2'd2
  } fstat_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_TEMP = 2'd0;
  localparam logic [1:0] CFG_DEADBAND = 2'd1;
  localparam logic [1:0] CFG_TICK_LIM = 2'd2;

  localparam logic [15:0] MAX_TEMP_RST = 16'd43067;
  localparam logic [15:0] DEADBAND_RST = 16'd187;
  localparam logic [7:0]  TICK_LIM_RST = 8'd5;
  localparam logic [15:0] TEMP_RST     = 16'd54300;
  localparam logic [15:0] SETPOINT_RST = 16'd35576;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_E_LOW = 8'h65;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_N_LOW = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Work handed from the front end to the output sequencer.
  typedef struct packed {
    logic        is_report;
    logic        heater;
    fstat_e      fstat;
    logic        reset_req;
    logic        ack;
    logic [15:0] temp_code;
    logic [7:0]  temp_check;
    logic [15:0] hum_code;
    logic [7:0]  hum_check;
  } job_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
    return crc8_byte(crc8_byte(CRC_INIT, hi), lo);
  endfunction

endpackage
`default_nettype wire

// File: hdl/incubator_heater_controller_core.sv
// On/off heater controller with hysteresis for an incubator.
// Slave stream: tuser carries the item kind (sensor reading, host frame
// byte, timer tick); tdata carries the sensor words, their CRC bytes and
// the host byte. Each sensor, host or tick item updates the controller
// state in the cycle it is accepted; every item is queued as a job for the
// output sequencer. Master stream: one item per status result, eleven per
// sensor reading (the report frame, one byte per cycle while the receiver
// is ready); tlast marks the final item of each input. tuser is 1 for a
// status item, 0 for a report byte. The output sequencer emits one item per
// cycle while the receiver is ready. A four-deep job queue lets the input
// keep flowing while the receiver stalls; s_axis_tready drops only when
// that queue is full. A held output item stays on the master port until
// taken. Reset returns control state and configuration to their defaults;
// the host frame store, job queue storage and output data registers are
// not cleared, and the frame store is only read once fully written.
// Configuration (max temperature, deadband, tick limit) is written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only while the
// block is idle, which the block itself does not enforce.
`default_nettype none
module incubator_heater_controller_core
  import ihc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // temp_code[15:0], temp_check[23:16], hum_code[39:24], hum_check[47:40],
  // host_byte[55:48]
  input  wire logic [55:0] s_axis_tdata,
  // cmd[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // report_byte[7:0], heater_on[8], frame_status[10:9], reset_request[11],
  // zero[15:12]
  output logic [15:0]      m_axis_tdata,
  // kind[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  logic accept;
  logic q_full, q_valid, q_pop;
  job_t new_job, head_job;

  logic       kind, last, heater_on, reset_request;
  logic [7:0] report_byte;
  logic [1:0] frame_status;

  // Accept whenever the job queue has room.
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ihc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .cmd_i        (s_axis_tuser),
    .temp_code_i  (s_axis_tdata[15:0]),
    .temp_check_i (s_axis_tdata[23:16]),
    .hum_code_i   (s_axis_tdata[39:24]),
    .hum_check_i  (s_axis_tdata[47:40]),
    .host_byte_i  (s_axis_tdata[55:48]),
    .job_o        (new_job)
  );

  // Hold jobs between classification and emission.
  ihc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_job_i (new_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  // Emit one output item per cycle into the output register while the receiver is ready.
  ihc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (q_valid),
    .job_i           (head_job),
    .pop_o           (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .kind_o          (kind),
    .report_byte_o   (report_byte),
    .last_o          (last),
    .heater_on_o     (heater_on),
    .frame_status_o  (frame_status),
    .reset_request_o (reset_request)
  );

  assign m_axis_tdata = {4'b0000, reset_request, frame_status, heater_on, report_byte};
  assign m_axis_tuser = kind;
  assign m_axis_tlast = last;

endmodule
`default_nettype wire

// File: hdl/ihc_front.sv
`default_nettype none
module ihc_front
  import ihc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        accept_i,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [15:0] temp_code_i,
  input  wire logic [7:0]  temp_check_i,
  input  wire logic [15:0] hum_code_i,
  input  wire logic [7:0]  hum_check_i,
  input  wire logic [7:0]  host_byte_i,
  output job_t             job_o
);

  logic [15:0] max_temp_q, deadband_q;
  logic [7:0]  tick_lim_q;
  logic [15:0] temp_q, temp_d;
  logic [15:0] setpoint_q, setpoint_d;
  logic        auto_q, auto_d;
  logic        run_q, run_d;
  logic        heater_q, heater_d;
  logic        ack_q, ack_d;
  logic [FrameIdxW-1:0] fcnt_q, fcnt_d;
  logic [7:0]  tick_q, tick_d;
  logic [7:0]  fstore_q [FrameLen];

  logic [15:0] temp_new;
  logic [16:0] low_bound;
  logic        heat_req;
  logic        heater_rule;
  fstat_e      fstat;
  logic        frame_done;
  logic        hdr_ok;
  logic        reset_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_temp_q <= MAX_TEMP_RST;
      deadband_q <= DEADBAND_RST;
      tick_lim_q <= TICK_LIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_TEMP: max_temp_q <= cfg_data_i;
        CFG_DEADBAND: deadband_q <= cfg_data_i;
        CFG_TICK_LIM: tick_lim_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sensor path: keep the new word only if its CRC matches.
  assign temp_new  = (crc8_word(temp_code_i[15:8], temp_code_i[7:0]) == temp_check_i)
                     ? temp_code_i : temp_q;
  assign low_bound = {1'b0, setpoint_q} - {1'b0, deadband_q};
  assign heat_req  = !low_bound[16] && (low_bound[15:0] > temp_new);

  always_comb begin
    heater_rule = heater_q;
    if (temp_new >= max_temp_q) begin
      heater_rule = 1'b0;
    end else if (!auto_q && !run_q) begin
      heater_rule = 1'b0;
    end else begin
      if (heat_req) heater_rule = 1'b1;
      if (temp_new > setpoint_q) heater_rule = 1'b0;
    end
  end

  // Host path: the eighth byte arrives on the port, the rest sit in the store.
  assign frame_done = (fcnt_q == FrameIdxW'(FrameLen - 1));
  assign hdr_ok = (fstore_q[0] == CH_S) && (fstore_q[1] == CH_E_LOW) &&
                  (fstore_q[6] == CH_E) && (host_byte_i == CH_N_LOW);

  always_comb begin
    fstat = FSTAT_REJECT;
    if (hdr_ok) begin
      case (fstore_q[2])
        CH_T: begin
          if (crc8_word(fstore_q[3], fstore_q[4]) == fstore_q[5]) fstat = FSTAT_ACCEPT;
        end
        CH_R, CH_P: fstat = FSTAT_ACCEPT;
        default: fstat = FSTAT_REJECT;
      endcase
    end
  end

  assign reset_req = (tick_q > tick_lim_q);

  always_comb begin
    temp_d     = temp_q;
    setpoint_d = setpoint_q;
    auto_d     = auto_q;
    run_d      = run_q;
    heater_d   = heater_q;
    ack_d      = ack_q;
    fcnt_d     = fcnt_q;
    tick_d     = tick_q;
    job_o      = '0;
    job_o.heater = heater_q;
    job_o.fstat  = FSTAT_NONE;
    unique case (cmd_e'(cmd_i))
      CMD_SENSOR: begin
        temp_d   = temp_new;
        heater_d = heater_rule;
        ack_d    = 1'b0;
        tick_d   = '0;
        job_o.is_report  = 1'b1;
        job_o.heater     = heater_rule;
        job_o.ack        = ack_q;
        job_o.temp_code  = temp_code_i;
        job_o.temp_check = temp_check_i;
        job_o.hum_code   = hum_code_i;
        job_o.hum_check  = hum_check_i;
      end
      CMD_HOST: begin
        fcnt_d = fcnt_q + 1'b1;
        if (frame_done) begin
          auto_d = 1'b0;
          job_o.fstat = fstat;
          if (fstat == FSTAT_ACCEPT) begin
            ack_d = 1'b1;
            case (fstore_q[2])
              CH_T:    setpoint_d = {fstore_q[3], fstore_q[4]};
              CH_R:    run_d = 1'b1;
              default: run_d = 1'b0;
            endcase
          end
        end
      end
      CMD_TICK: begin
        if (reset_req) begin
          heater_d = 1'b0;
          job_o.heater    = 1'b0;
          job_o.reset_req = 1'b1;
        end
        if (tick_q != 8'hFF) tick_d = tick_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q     <= TEMP_RST;
      setpoint_q <= SETPOINT_RST;
      auto_q     <= 1'b1;
      run_q      <= 1'b0;
      heater_q   <= 1'b0;
      ack_q      <= 1'b0;
      fcnt_q     <= '0;
      tick_q     <= '0;
    end else if (accept_i) begin
      temp_q     <= temp_d;
      setpoint_q <= setpoint_d;
      auto_q     <= auto_d;
      run_q      <= run_d;
      heater_q   <= heater_d;
      ack_q      <= ack_d;
      fcnt_q     <= fcnt_d;
      tick_q     <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && (cmd_e'(cmd_i) == CMD_HOST)) begin
      fstore_q[fcnt_q] <= host_byte_i;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ihc_queue.sv
`default_nettype none
module ihc_queue
  import ihc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      head_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_job_i;
  end

endmodule
`default_nettype wire

// File: hdl/ihc_back.sv
`default_nettype none
module ihc_back
  import ihc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  input  wire job_t  job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic       kind_o,
  output logic [7:0] report_byte_o,
  output logic       last_o,
  output logic       heater_on_o,
  output logic [1:0] frame_status_o,
  output logic       reset_request_o
);

  logic                  valid_q;
  logic [ReportIdxW-1:0] idx_q;
  logic                  load;
  logic                  last_d;
  logic [7:0]            byte_d;

  logic       kind_q, last_q, heater_q, rreq_q;
  logic [7:0] byte_q;
  logic [1:0] fstat_q;

  assign load   = job_valid_i && (!valid_q || out_ready_i);
  assign last_d = !job_i.is_report || (idx_q == ReportIdxW'(ReportLen - 1));
  assign pop_o  = load && last_d;

  always_comb begin
    unique case (idx_q)
      4'd0:    byte_d = CH_S;
      4'd1:    byte_d = CH_E_LOW;
      4'd2:    byte_d = job_i.temp_code[15:8];
      4'd3:    byte_d = job_i.temp_code[7:0];
      4'd4:    byte_d = job_i.temp_check;
      4'd5:    byte_d = job_i.hum_code[15:8];
      4'd6:    byte_d = job_i.hum_code[7:0];
      4'd7:    byte_d = job_i.hum_check;
      4'd8:    byte_d = job_i.ack ? CH_PLUS : CH_MINUS;
      4'd9:    byte_d = CH_E;
      4'd10:   byte_d = CH_N_LOW;
      default: byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last_d ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= !job_i.is_report;
      byte_q   <= job_i.is_report ? byte_d : 8'h00;
      last_q   <= last_d;
      heater_q <= job_i.heater;
      fstat_q  <= job_i.fstat;
      rreq_q   <= job_i.reset_req;
    end
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = kind_q;
  assign report_byte_o   = byte_q;
  assign last_o          = last_q;
  assign heater_on_o     = heater_q;
  assign frame_status_o  = fstat_q;
  assign reset_request_o = rreq_q;

endmodule
`default_nettype wire
